// ===== hw/rtl/sbpv_pkg.sv =====
// Package for the sample playback voice: command and register codes, fixed widths,
// and the read stage status struct. Has no dependencies.
package sbpv_pkg;

    localparam int POS_W   = 15;   // play position and buffer length width
    localparam int FRAME_W = 14;   // frame index width
    localparam int TICK_W  = 32;   // time counter width
    localparam int CFG_W   = 15;   // widest register
    localparam int CIDX_W  = 3;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_t;

    typedef enum logic [CIDX_W-1:0] {
        REG_BUFFER_LENGTH   = 3'd0,
        REG_BUFFER_CHANNELS = 3'd1,
        REG_LOOP_ENABLE     = 3'd2,
        REG_LOOP_START      = 3'd3,
        REG_START_OFFSET    = 3'd4,
        REG_PLAY_LENGTH     = 3'd5
    } reg_idx_t;

    // status of a tick while its frame is being read from the store
    typedef struct packed {
        logic ended;
        logic playing;
        logic play;      // a frame is read, else silence
        logic stereo;
        logic in_range;  // position below store depth
    } rd_stage_t;

endpackage

// ===== hw/rtl/sbpv_ram.sv =====
// Generic simple dual port RAM with one write port and one registered read port.
// No dependencies.
module sbpv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/sample_buffer_playback_voice.sv =====
// Sample playback voice top level: command decode, play state, two store RAMs.
// Depends on sbpv_pkg and sbpv_ram.
//
//  port group   dir  handshake         carries
//  s_*          in   s_valid/s_ready   command, sample write fields, delay
//  m_*          out  m_valid/m_ready   left/right frame, ended, playing
//  cfg_*        in   cfg_we            register index and data, no read-back
//
// One item per cycle sustained while the output is not stalled. A tick reads both
// store RAMs in the cycle it is accepted; the frame then passes from the read stage
// into the output register. Reset is synchronous and clears the play state and
// registers; the store is not cleared.
// s_ready drops only when the read stage and the output hold frames and m_ready is low.
module sample_buffer_playback_voice #(
    parameter int MAX_FRAMES  = 16384,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_command,
    input  logic [sbpv_pkg::FRAME_W-1:0]        s_sample_address,
    input  logic                                s_sample_channel,
    input  logic signed [SAMPLE_BITS-1:0]       s_sample_value,
    input  logic [sbpv_pkg::TICK_W-1:0]         s_delay_ticks,
    // result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [SAMPLE_BITS-1:0]       m_left_out,
    output logic signed [SAMPLE_BITS-1:0]       m_right_out,
    output logic                                m_ended,
    output logic                                m_playing,
    // configuration
    input  logic                                cfg_we,
    input  logic [sbpv_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [sbpv_pkg::CFG_W-1:0]          cfg_data
);

    localparam int AW = $clog2(MAX_FRAMES);
    localparam int CW = (AW + 1 > sbpv_pkg::POS_W) ? AW + 1 : sbpv_pkg::POS_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(MAX_FRAMES);

    // configuration registers
    logic [sbpv_pkg::POS_W-1:0]   buffer_length_reg;
    logic [1:0]                   buffer_channels_reg;
    logic                         loop_enable_reg;
    logic [sbpv_pkg::FRAME_W-1:0] loop_start_reg;
    logic [sbpv_pkg::FRAME_W-1:0] start_offset_reg;
    logic [sbpv_pkg::POS_W-1:0]   play_length_reg;

    // play state
    logic [sbpv_pkg::POS_W-1:0]   position_reg, position_next;
    logic [sbpv_pkg::TICK_W-1:0]  time_reg, time_next;
    logic [sbpv_pkg::TICK_W-1:0]  start_tick_reg, start_tick_next;
    logic [sbpv_pkg::TICK_W-1:0]  stop_tick_reg, stop_tick_next;
    logic                         stop_armed_reg, stop_armed_next;
    logic                         active_reg, active_next;
    logic [sbpv_pkg::FRAME_W-1:0] lat_offset_reg, lat_offset_next;
    logic [sbpv_pkg::POS_W-1:0]   lat_length_reg, lat_length_next;

    // read stage and output register
    logic                         rd_valid_reg, rd_valid_next;
    sbpv_pkg::rd_stage_t          rd_reg, rd_next;
    logic                         out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_left_reg, out_right_reg;
    logic                         out_ended_reg, out_playing_reg;

    logic                         accept, is_tick, rd_adv;
    sbpv_pkg::cmd_t               cmd;
    logic [SAMPLE_BITS-1:0]       rdata_l, rdata_r;
    logic signed [SAMPLE_BITS-1:0] frame_l, frame_r;

    // tick decisions
    logic                         stop_hit, started, past_end, end_buf, dur_end;
    logic                         tick_run, go, ended;
    logic [sbpv_pkg::POS_W-1:0]   pos_eff;
    logic signed [sbpv_pkg::POS_W:0] pos_diff;
    logic [sbpv_pkg::TICK_W:0]    arm_sum;
    logic [sbpv_pkg::TICK_W-1:0]  arm_tick;
    logic [CW-1:0]                rd_pos_c, wr_addr_c;
    logic                         wr_in_range, we_l, we_r;

    assign cmd     = sbpv_pkg::cmd_t'(s_command);
    assign rd_adv  = rd_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !rd_valid_reg || rd_adv;
    assign accept  = s_valid && s_ready;
    assign is_tick = accept && (cmd == sbpv_pkg::CMD_TICK);

    // saturating arm time
    assign arm_sum  = {1'b0, time_reg} + {1'b0, s_delay_ticks};
    assign arm_tick = arm_sum[sbpv_pkg::TICK_W] ? '1 : arm_sum[sbpv_pkg::TICK_W-1:0];

    always_comb begin
        stop_hit = stop_armed_reg && (time_reg >= stop_tick_reg);
        started  = time_reg >= start_tick_reg;
        past_end = position_reg >= buffer_length_reg;
        pos_eff  = (past_end && loop_enable_reg) ? {1'b0, loop_start_reg} : position_reg;
        end_buf  = past_end &&
                   (!loop_enable_reg || ({1'b0, loop_start_reg} >= buffer_length_reg));
        // signed distance from the latched offset; a loop below it goes negative
        pos_diff = $signed({1'b0, pos_eff}) - $signed({2'b00, lat_offset_reg});
        dur_end  = (lat_length_reg != '0) && !end_buf &&
                   (pos_diff >= $signed({1'b0, lat_length_reg}));
        tick_run = active_reg && !stop_hit && started;
        go       = tick_run && !end_buf && !dur_end;
        ended    = active_reg && (stop_hit || (started && (end_buf || dur_end)));
    end

    assign rd_pos_c = CW'(pos_eff);

    always_comb begin
        position_next   = position_reg;
        time_next       = time_reg;
        start_tick_next = start_tick_reg;
        stop_tick_next  = stop_tick_reg;
        stop_armed_next = stop_armed_reg;
        active_next     = active_reg;
        lat_offset_next = lat_offset_reg;
        lat_length_next = lat_length_reg;
        rd_valid_next   = rd_adv ? 1'b0 : rd_valid_reg;
        rd_next         = rd_reg;
        if (accept) begin
            case (cmd)
                sbpv_pkg::CMD_START: begin
                    if (!active_reg) begin
                        start_tick_next = arm_tick;
                        lat_offset_next = start_offset_reg;
                        lat_length_next = play_length_reg;
                        position_next   = {1'b0, start_offset_reg};
                        active_next     = 1'b1;
                    end
                end
                sbpv_pkg::CMD_STOP: begin
                    if (active_reg) begin
                        stop_tick_next  = arm_tick;
                        stop_armed_next = 1'b1;
                    end
                end
                sbpv_pkg::CMD_TICK: begin
                    if (tick_run) begin
                        position_next = go ? pos_eff + 1'b1 : pos_eff;
                    end
                    if (ended) begin
                        active_next     = 1'b0;
                        stop_armed_next = 1'b0;
                    end
                    time_next        = time_reg + 1'b1;
                    rd_valid_next    = 1'b1;
                    rd_next.ended    = ended;
                    rd_next.playing  = active_reg && !ended;
                    rd_next.play     = go;
                    rd_next.stereo   = buffer_channels_reg[1];
                    rd_next.in_range = rd_pos_c < DEPTH_C;
                end
                default: ;
            endcase
        end
    end

    // sample writes
    assign wr_addr_c   = CW'(s_sample_address);
    assign wr_in_range = wr_addr_c < DEPTH_C;
    assign we_l = accept && (cmd == sbpv_pkg::CMD_WRITE) && wr_in_range && !s_sample_channel;
    assign we_r = accept && (cmd == sbpv_pkg::CMD_WRITE) && wr_in_range && s_sample_channel;

    sbpv_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_FRAMES)) u_ram_left (
        .aclk  (aclk),
        .we    (we_l),
        .waddr (wr_addr_c[AW-1:0]),
        .wdata (s_sample_value),
        .re    (is_tick),
        .raddr (rd_pos_c[AW-1:0]),
        .rdata (rdata_l)
    );

    sbpv_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_FRAMES)) u_ram_right (
        .aclk  (aclk),
        .we    (we_r),
        .waddr (wr_addr_c[AW-1:0]),
        .wdata (s_sample_value),
        .re    (is_tick),
        .raddr (rd_pos_c[AW-1:0]),
        .rdata (rdata_r)
    );

    // stored samples already fit the output range, so no saturation is needed
    always_comb begin
        frame_l = (rd_reg.play && rd_reg.in_range) ? $signed(rdata_l) : '0;
        frame_r = rd_reg.stereo ? ((rd_reg.play && rd_reg.in_range) ? $signed(rdata_r) : '0)
                                : frame_l;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_length_reg   <= '0;
            buffer_channels_reg <= 2'd1;
            loop_enable_reg     <= 1'b0;
            loop_start_reg      <= '0;
            start_offset_reg    <= '0;
            play_length_reg     <= '0;
        end else if (cfg_we) begin
            case (sbpv_pkg::reg_idx_t'(cfg_index))
                sbpv_pkg::REG_BUFFER_LENGTH:   buffer_length_reg   <= cfg_data;
                sbpv_pkg::REG_BUFFER_CHANNELS: buffer_channels_reg <= cfg_data[1:0];
                sbpv_pkg::REG_LOOP_ENABLE:     loop_enable_reg     <= cfg_data[0];
                sbpv_pkg::REG_LOOP_START:      loop_start_reg      <= cfg_data[sbpv_pkg::FRAME_W-1:0];
                sbpv_pkg::REG_START_OFFSET:    start_offset_reg    <= cfg_data[sbpv_pkg::FRAME_W-1:0];
                sbpv_pkg::REG_PLAY_LENGTH:     play_length_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg   <= '0;
            time_reg       <= '0;
            start_tick_reg <= '0;
            stop_tick_reg  <= '0;
            stop_armed_reg <= 1'b0;
            active_reg     <= 1'b0;
            lat_offset_reg <= '0;
            lat_length_reg <= '0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            position_reg   <= position_next;
            time_reg       <= time_next;
            start_tick_reg <= start_tick_next;
            stop_tick_reg  <= stop_tick_next;
            stop_armed_reg <= stop_armed_next;
            active_reg     <= active_next;
            lat_offset_reg <= lat_offset_next;
            lat_length_reg <= lat_length_next;
            rd_valid_reg   <= rd_valid_next;
            if (rd_adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_reg <= rd_next;
        if (rd_adv) begin
            out_left_reg    <= frame_l;
            out_right_reg   <= frame_r;
            out_ended_reg   <= rd_reg.ended;
            out_playing_reg <= rd_reg.playing;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_left_out  = out_left_reg;
    assign m_right_out = out_right_reg;
    assign m_ended     = out_ended_reg;
    assign m_playing   = out_playing_reg;

`ifndef NO_ASSERTIONS
    a_end_not_playing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_ended && m_playing))
        else $error("frame reports ended while still playing");

    a_end_is_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ended) |-> (m_left_out == '0 && m_right_out == '0))
        else $error("ending frame is not silent");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("input accepted while read stage is stalled");

    a_end_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(active_reg) |-> $past(is_tick))
        else $error("voice went inactive without a tick");
`endif

endmodule
